// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pps assertion failed");

// next-cycle implication
`define PPS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pps assertion failed");

`endif

// ===== hdl/pps_pkg.sv =====
// types, constants and helpers of the preemptive priority scheduler
package pps_pkg;

    localparam int TIME_W = 20;
    localparam logic [TIME_W-1:0] TIME_MAX = 20'hFFFFF;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  task_id;
        logic [6:0]  task_priority;
        logic [15:0] arrival_time;
        logic [15:0] burst_length;
    } t_req;

    typedef struct packed {
        logic              idle_slot;
        logic [7:0]        granted_id;
        logic [TIME_W-1:0] slot_start;
        logic [TIME_W-1:0] slot_end;
        logic              task_finished;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic              all_done;
    } t_rsp;

    typedef struct packed {
        logic [7:0]  task_id;
        logic [6:0]  task_priority;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [15:0] remaining;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // a wins over b: lower priority value, then earlier arrival, then shorter burst
    function automatic logic pps_beats(input t_entry a, input t_entry b);
        logic res;
        if (a.task_priority != b.task_priority) begin
            res = a.task_priority < b.task_priority;
        end else if (a.arrival != b.arrival) begin
            res = a.arrival < b.arrival;
        end else begin
            res = a.burst < b.burst;
        end
        return res;
    endfunction

endpackage

// ===== hdl/pps_stream_if.sv =====
// valid/ready channel carrying one request or result
interface pps_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/pps_table.sv =====
// task table memory, one write port and one registered read port
module pps_table import pps_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/preemptive_priority_scheduler.sv =====
// preemptive priority scheduler top level
// a load request is written to the task table unless it is full; it gives no result
// a step request reads the task table one entry per cycle through the single
// memory read port, then waits for the result port and registers its result;
// no new request is taken until then (a step with no task pending gives no result)
// synchronous active-low reset clears entry count, pending count and time
module preemptive_priority_scheduler import pps_pkg::*; #(
    parameter int MAX_TASKS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pps_stream_if.sink    i_req,
    pps_stream_if.source  o_rsp
);

    localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_TASKS);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_pend, n_pend;
    logic [TIME_W-1:0] r_time, n_time;
    logic [CW-1:0]     r_scan, n_scan;
    logic              r_rd_vld, n_rd_vld;
    logic [AW-1:0]     r_rd_idx, n_rd_idx;
    logic              r_found, n_found;
    logic [AW-1:0]     r_best_idx, n_best_idx;
    t_entry            r_best, n_best;
    logic [TIME_W-1:0] r_next, n_next;
    logic              r_out_vld, n_out_vld;
    t_rsp              r_out, n_out;

    logic              we;
    logic [AW-1:0]     waddr;
    t_entry            wdata;
    t_entry            rdata;
    logic              issue;
    logic              elig;
    logic              later;

    logic [TIME_W-1:0] t_end;
    logic [TIME_W-1:0] tat;
    logic [TIME_W-1:0] wt;
    logic [15:0]       rem_dec;
    logic              fin;
    logic [CW-1:0]     pend_after;

    pps_table #(
        .DEPTH (MAX_TASKS),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_scan[AW-1:0]),
        .o_rdata (rdata)
    );

    assign elig  = (rdata.remaining != '0) && (TIME_W'(rdata.arrival) <= r_time);
    assign later = (rdata.remaining != '0) && (TIME_W'(rdata.arrival) > r_time)
                   && (TIME_W'(rdata.arrival) < r_next);

    assign t_end      = (r_time == TIME_MAX) ? TIME_MAX : r_time + TIME_W'(1);
    assign tat        = t_end - TIME_W'(r_best.arrival);
    assign wt         = (tat >= TIME_W'(r_best.burst)) ? tat - TIME_W'(r_best.burst) : '0;
    assign rem_dec    = r_best.remaining - 16'd1;
    assign fin        = (rem_dec == '0);
    assign pend_after = r_pend - CW'(fin);

    assign i_req.ready = (r_state == ST_IDLE);
    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_pend     = r_pend;
        n_time     = r_time;
        n_scan     = r_scan;
        n_rd_vld   = 1'b0;
        n_rd_idx   = r_rd_idx;
        n_found    = r_found;
        n_best_idx = r_best_idx;
        n_best     = r_best;
        n_next     = r_next;
        n_out_vld  = r_out_vld && !o_rsp.ready;
        n_out      = r_out;
        we         = 1'b0;
        waddr      = r_count[AW-1:0];
        wdata      = '{task_id:       i_req.data.task_id,
                       task_priority: i_req.data.task_priority,
                       arrival:       i_req.data.arrival_time,
                       burst:         i_req.data.burst_length,
                       remaining:     i_req.data.burst_length};
        issue      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.data.kind == KIND_LOAD) begin
                        if (r_count != FULL) begin
                            we      = 1'b1;
                            n_count = r_count + CW'(1);
                            if (i_req.data.burst_length != '0) begin
                                n_pend = r_pend + CW'(1);
                            end
                        end
                    end else if (r_pend != '0) begin
                        n_state = ST_SCAN;
                        n_scan  = '0;
                        n_found = 1'b0;
                        n_next  = TIME_MAX;
                    end
                end
            end
            ST_SCAN: begin
                issue    = (r_scan < r_count);
                n_rd_vld = issue;
                n_rd_idx = r_scan[AW-1:0];
                if (issue) begin
                    n_scan = r_scan + CW'(1);
                end
                if (r_rd_vld) begin
                    if (elig) begin
                        if (!r_found || pps_beats(rdata, r_best)) begin
                            n_found    = 1'b1;
                            n_best     = rdata;
                            n_best_idx = r_rd_idx;
                        end
                    end else if (later) begin
                        n_next = TIME_W'(rdata.arrival);
                    end
                end
                if (!issue && !r_rd_vld) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_out_vld        = 1'b1;
                    n_out.slot_start = r_time;
                    n_state          = ST_IDLE;
                    if (r_found) begin
                        we                  = 1'b1;
                        waddr               = r_best_idx;
                        wdata               = r_best;
                        wdata.remaining     = rem_dec;
                        n_time              = t_end;
                        n_pend              = pend_after;
                        n_out.idle_slot     = 1'b0;
                        n_out.granted_id    = r_best.task_id;
                        n_out.slot_end      = t_end;
                        n_out.task_finished = fin;
                        n_out.turnaround    = fin ? tat : '0;
                        n_out.waiting       = fin ? wt : '0;
                        n_out.all_done      = (pend_after == '0);
                    end else begin
                        n_time              = r_next;
                        n_out.idle_slot     = 1'b1;
                        n_out.granted_id    = '0;
                        n_out.slot_end      = r_next;
                        n_out.task_finished = 1'b0;
                        n_out.turnaround    = '0;
                        n_out.waiting       = '0;
                        n_out.all_done      = (r_pend == '0);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_pend    <= '0;
            r_time    <= '0;
            r_scan    <= '0;
            r_rd_vld  <= 1'b0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_pend    <= n_pend;
            r_time    <= n_time;
            r_scan    <= n_scan;
            r_rd_vld  <= n_rd_vld;
            r_found   <= n_found;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_best_idx <= n_best_idx;
        r_best     <= n_best;
        r_next     <= n_next;
        r_out      <= n_out;
    end

endmodule

// ===== hdl/pps_chk.sv =====
// result port checks of the scheduler, bound to the top level
`include "assert_macros.svh"

module pps_chk import pps_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic i_ready,
    input t_rsp i_rsp
);

    // stalled result stays put
    `PPS_ASSERT_NXT(a_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_rsp))

    // idle slot grants nothing and moves time forward
    `PPS_ASSERT_IMP(a_idle, i_clk, i_rst_n, i_valid && i_rsp.idle_slot, (i_rsp.granted_id == '0) && !i_rsp.task_finished && (i_rsp.slot_end > i_rsp.slot_start))

    // granted slot lasts one unit unless time is saturated
    `PPS_ASSERT_IMP(a_unit, i_clk, i_rst_n, i_valid && !i_rsp.idle_slot, (i_rsp.slot_end == i_rsp.slot_start + TIME_W'(1)) || ((i_rsp.slot_start == TIME_MAX) && (i_rsp.slot_end == TIME_MAX)))

    // times only reported for a finished task
    `PPS_ASSERT_IMP(a_times, i_clk, i_rst_n, i_valid && !i_rsp.task_finished, (i_rsp.turnaround == '0) && (i_rsp.waiting == '0))

    // waiting never exceeds turnaround
    `PPS_ASSERT_IMP(a_wait, i_clk, i_rst_n, i_valid, i_rsp.waiting <= i_rsp.turnaround)

endmodule

bind preemptive_priority_scheduler pps_chk u_pps_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_rsp.valid),
    .i_ready (o_rsp.ready),
    .i_rsp   (o_rsp.data)
);
